@@ hw/rtl/rrfsd_pkg.sv @@
// Types and constants shared by the round-robin server dispatch block.
package rrfsd_pkg;

    localparam int unsigned TIME_W  = 31;
    localparam int unsigned BUSY_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned SIDX_W  = 5;
    localparam int unsigned CFG_W   = 6;
    localparam logic [CFG_W-1:0] SERVER_COUNT_RST = 6'd32;

    typedef logic [SIDX_W-1:0] t_srv_idx;

    typedef struct packed {
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] service_time;
        logic              final_request;
    } t_req;

    typedef struct packed {
        logic [SIDX_W-1:0]  server_index;
        logic [COUNT_W-1:0] handled_count;
        logic               end_of_list;
    } t_rsp;

endpackage

@@ hw/rtl/rrfsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rrfsd_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/round_robin_free_server_dispatch.sv @@
// Top level: round-robin first-free server dispatch with busiest-server report.
//
//  channel   | handshake            | payload         | direction
//  ----------+----------------------+-----------------+----------
//  request   | i_valid / o_ready    | i_req (t_req)   | in
//  report    | o_valid / i_ready    | o_rsp (t_rsp)   | out
//  config    | i_cfg_we             | i_cfg_data      | in
//
// A request scans servers through one shared RAM port and one comparator,
// reading each server in S_RD and testing it in S_CHK.
// A request marked final then takes two passes over the counters, the second
// stalling with the report side; each listed server is one item.
// The busy/count RAM is cleared by dropping every server's valid bit at once,
// at reset and at the end of each report.
// o_ready is high only while the sequencer is idle; a finished report item
// may still wait in the output register while the next request is taken.
module round_robin_free_server_dispatch #(
    parameter int unsigned MAX_SERVERS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  rrfsd_pkg::t_req            i_req,
    output logic                       o_valid,
    input  logic                       i_ready,
    output rrfsd_pkg::t_rsp            o_rsp,
    input  logic                       i_cfg_we,
    input  logic [rrfsd_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int unsigned IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int unsigned KW = $clog2(MAX_SERVERS + 1);
    localparam int unsigned CW = rrfsd_pkg::CFG_W + 1;
    localparam int unsigned RW = rrfsd_pkg::BUSY_W + rrfsd_pkg::COUNT_W;
    localparam logic [CW-1:0] MAX_K = CW'(MAX_SERVERS);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;  // read server under scan
    localparam logic [2:0] S_CHK  = 3'd2;  // test free, claim it
    localparam logic [2:0] S_MRD  = 3'd3;  // read counter for maximum
    localparam logic [2:0] S_MCHK = 3'd4;  // track maximum and ties
    localparam logic [2:0] S_LRD  = 3'd5;  // read counter for listing
    localparam logic [2:0] S_LCHK = 3'd6;  // emit matching server

    logic [2:0]                      r_state, n_state;
    logic [rrfsd_pkg::CFG_W-1:0]     r_cfg;
    logic [MAX_SERVERS-1:0]          r_vld, n_vld;
    logic [IW-1:0]                   r_sp, n_sp;
    logic [IW-1:0]                   r_id, n_id;
    logic [IW-1:0]                   r_j, n_j;
    logic [KW-1:0]                   r_ties, n_ties;
    logic [KW-1:0]                   r_emit, n_emit;
    logic [rrfsd_pkg::COUNT_W-1:0]   r_top, n_top;
    rrfsd_pkg::t_req                 r_req;
    logic                            r_out_v, n_out_v;
    rrfsd_pkg::t_rsp                 r_rsp, n_rsp;

    logic [CW-1:0]                   w_kc;
    logic [KW-1:0]                   w_k;
    logic [KW-1:0]                   w_km1;
    logic [IW-1:0]                   w_start;
    logic                            w_accept;
    logic                            w_last_j;
    logic                            w_slot;
    logic                            w_load;
    logic                            w_re;
    logic                            w_we;
    logic [IW-1:0]                   w_raddr;
    logic [RW-1:0]                   w_rdata;
    logic [RW-1:0]                   w_wdata;
    logic [rrfsd_pkg::BUSY_W-1:0]    w_busy;
    logic [rrfsd_pkg::COUNT_W-1:0]   w_cnt;
    logic [rrfsd_pkg::COUNT_W-1:0]   w_cnt_inc;
    logic [rrfsd_pkg::BUSY_W-1:0]    w_until;
    logic                            w_rd_vld;

    // Servers in use: zero means one, clamp at the store depth.
    always_comb begin
        w_kc = (r_cfg == '0) ? CW'(1) : CW'(r_cfg);
        if (w_kc > MAX_K) begin
            w_kc = MAX_K;
        end
        w_k   = KW'(w_kc);
        w_km1 = w_k - KW'(1);
    end

    // A stale pointer (k lowered mid-batch) restarts the scan at server 0.
    assign w_start  = (KW'(r_sp) < w_k) ? r_sp : '0;
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_last_j = (KW'(r_j) == w_km1);
    assign w_slot   = !r_out_v || i_ready;

    // Entries never written since the last clear read as zero.
    assign w_rd_vld  = r_vld[(r_state == S_CHK) ? r_id : r_j];
    assign w_busy    = w_rd_vld ? w_rdata[RW-1 -: rrfsd_pkg::BUSY_W] : '0;
    assign w_cnt     = w_rd_vld ? w_rdata[rrfsd_pkg::COUNT_W-1:0] : '0;
    assign w_cnt_inc = (w_cnt == '1) ? w_cnt : w_cnt + rrfsd_pkg::COUNT_W'(1);
    assign w_until   = rrfsd_pkg::BUSY_W'(r_req.arrival_time)
                     + rrfsd_pkg::BUSY_W'(r_req.service_time);

    assign w_re    = (r_state == S_RD) || (r_state == S_MRD) || (r_state == S_LRD);
    assign w_raddr = (r_state == S_RD) ? r_id : r_j;
    assign w_we    = (r_state == S_CHK)
                  && (w_busy <= rrfsd_pkg::BUSY_W'(r_req.arrival_time));
    assign w_wdata = {w_until, w_cnt_inc};
    assign w_load  = (r_state == S_LCHK) && (w_cnt == r_top) && w_slot;

    rrfsd_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SERVERS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_id),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_vld   = r_vld;
        n_sp    = r_sp;
        n_id    = r_id;
        n_j     = r_j;
        n_ties  = r_ties;
        n_emit  = r_emit;
        n_top   = r_top;
        n_out_v = r_out_v && !i_ready;
        n_rsp   = r_rsp;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_id    = w_start;
                    n_j     = '0;
                    n_sp    = (KW'(w_start) == w_km1) ? '0 : w_start + IW'(1);
                    n_top   = '0;
                    n_ties  = '0;
                    n_emit  = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (w_we || w_last_j) begin
                    // claim done or every server busy: drop
                    if (w_we) begin
                        n_vld[r_id] = 1'b1;
                    end
                    n_j     = '0;
                    n_state = r_req.final_request ? S_MRD : S_IDLE;
                end else begin
                    n_id    = (KW'(r_id) == w_km1) ? '0 : r_id + IW'(1);
                    n_j     = r_j + IW'(1);
                    n_state = S_RD;
                end
            end
            S_MRD: begin
                n_state = S_MCHK;
            end
            S_MCHK: begin
                if (w_cnt > r_top) begin
                    n_top  = w_cnt;
                    n_ties = KW'(1);
                end else if (w_cnt == r_top) begin
                    n_ties = r_ties + KW'(1);
                end
                if (w_last_j) begin
                    n_j     = '0;
                    n_state = S_LRD;
                end else begin
                    n_j     = r_j + IW'(1);
                    n_state = S_MRD;
                end
            end
            S_LRD: begin
                n_state = S_LCHK;
            end
            S_LCHK: begin
                if (w_load) begin
                    n_out_v             = 1'b1;
                    n_rsp.server_index  = rrfsd_pkg::t_srv_idx'(r_j);
                    n_rsp.handled_count = r_top;
                    n_rsp.end_of_list   = ((r_emit + KW'(1)) == r_ties);
                    n_emit              = r_emit + KW'(1);
                end
                // hold while a match waits for the output slot
                if (w_cnt != r_top || w_slot) begin
                    if (w_last_j) begin
                        n_vld   = '0;
                        n_sp    = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + IW'(1);
                        n_state = S_LRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= rrfsd_pkg::SERVER_COUNT_RST;
            r_vld   <= '0;
            r_sp    <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_sp    <= n_sp;
            r_out_v <= n_out_v;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        r_id   <= n_id;
        r_j    <= n_j;
        r_ties <= n_ties;
        r_emit <= n_emit;
        r_top  <= n_top;
        r_rsp  <= n_rsp;
    end

    assign o_valid = r_out_v;
    assign o_rsp   = r_rsp;

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (KW'(r_id) < w_k))
        else $error("scan index beyond servers in use");

    a_ties_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LRD) |-> (r_ties != '0))
        else $error("listing pass with no tied server");

    a_all_listed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LCHK) ##1 (r_state == S_IDLE)) |-> (r_emit == r_ties))
        else $error("report item count differs from tie count");

    a_store_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LCHK) ##1 (r_state == S_IDLE)) |-> (r_vld == '0))
        else $error("store not cleared after report");
`endif

endmodule

@@ tb/round_robin_free_server_dispatch_tb.sv @@
// Self-checking testbench for the round-robin first-free server dispatch block.
module round_robin_free_server_dispatch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_SERVERS  = 32;
    // Worst case for one request: a scan over k servers, then two passes over the counters.
    localparam int unsigned DRAIN_CYCLES = 300;
    // Long receiver hold-off that backs the block up into its input.
    localparam int unsigned HOLD_CYCLES  = 600;
    // Cycles with no accepted item before the run is declared hung.
    localparam int unsigned STALL_LIMIT  = 8000;
    localparam int unsigned RANDOM_ITEMS = 430;

    logic                        i_clk;
    logic                        i_rst_n    = 1'b0;
    logic                        i_valid    = 1'b0;
    logic                        o_ready;
    rrfsd_pkg::t_req             i_req      = '0;
    logic                        o_valid;
    logic                        i_ready    = 1'b0;
    rrfsd_pkg::t_rsp             o_rsp;
    logic                        i_cfg_we   = 1'b0;
    logic [rrfsd_pkg::CFG_W-1:0] i_cfg_data = '0;

    round_robin_free_server_dispatch #(
        .MAX_SERVERS(MAX_SERVERS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Dispatch model: its own copy of the server store and the register.
    // ------------------------------------------------------------------
    logic [rrfsd_pkg::BUSY_W-1:0]  free_at   [MAX_SERVERS];
    logic [rrfsd_pkg::COUNT_W-1:0] jobs_done [MAX_SERVERS];
    int unsigned                   scan_origin;
    logic [rrfsd_pkg::CFG_W-1:0]   server_setting;

    // Busiest-server list items still owed by the block, oldest first.
    rrfsd_pkg::t_rsp busiest_queue[$];

    int unsigned mismatches     = 0;
    int unsigned requests_sent  = 0;
    int unsigned reports_seen   = 0;
    int unsigned register_writes = 0;

    // Phase controls shared with the receiver process.
    bit calm_phase = 1'b0;
    bit hold_req   = 1'b0;
    bit holding    = 1'b0;

    function automatic int unsigned servers_in_use();
        if (server_setting == 0) return 1;
        if (server_setting > MAX_SERVERS) return MAX_SERVERS;
        return int'(server_setting);
    endfunction

    task automatic clear_servers();
        for (int unsigned j = 0; j < MAX_SERVERS; j++) begin
            free_at[j]   = '0;
            jobs_done[j] = '0;
        end
        scan_origin = 0;
    endtask

    // Place one request on the first free server and, on a final request,
    // queue the list of busiest servers, then wipe the store.
    task automatic dispatch_request(input rrfsd_pkg::t_req r);
        int unsigned                   k;
        int unsigned                   start;
        int unsigned                   id;
        int unsigned                   last_j;
        bit                            placed;
        logic [rrfsd_pkg::COUNT_W-1:0] top;
        rrfsd_pkg::t_rsp               item;
        k      = servers_in_use();
        start  = (scan_origin < k) ? scan_origin : 0;
        placed = 1'b0;
        for (int unsigned j = 0; j < k; j++) begin
            id = start + j;
            if (id >= k) id -= k;
            if (!placed && free_at[id] <= {1'b0, r.arrival_time}) begin
                free_at[id] = {1'b0, r.arrival_time} + {1'b0, r.service_time};
                if (jobs_done[id] != '1) jobs_done[id] = jobs_done[id] + 1'b1;
                placed = 1'b1;
            end
        end
        scan_origin = (start + 1 >= k) ? 0 : start + 1;
        if (r.final_request) begin
            top = '0;
            for (int unsigned j = 0; j < k; j++) begin
                if (jobs_done[j] > top) top = jobs_done[j];
            end
            last_j = 0;
            for (int unsigned j = 0; j < k; j++) begin
                if (jobs_done[j] == top) last_j = j;
            end
            for (int unsigned j = 0; j < k; j++) begin
                if (jobs_done[j] == top) begin
                    item.server_index  = rrfsd_pkg::SIDX_W'(j);
                    item.handled_count = top;
                    item.end_of_list   = (j == last_j);
                    busiest_queue.push_back(item);
                end
            end
            clear_servers();
        end
    endtask

    // ------------------------------------------------------------------
    // Report side: random ready, plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin
        forever begin
            if (hold_req) begin
                holding = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holding  = 1'b0;
                hold_req = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Compare every accepted list item with the oldest one owed.
    always @(posedge i_clk) begin
        rrfsd_pkg::t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            reports_seen++;
            if (busiest_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected item server %0d count %0d",
                                          o_rsp.server_index, o_rsp.handled_count));
            end else begin
                want = busiest_queue.pop_front();
                if (o_rsp.server_index !== want.server_index)
                    report_mismatch($sformatf("server_index got %0d want %0d",
                                              o_rsp.server_index, want.server_index));
                if (o_rsp.handled_count !== want.handled_count)
                    report_mismatch($sformatf("handled_count got %0d want %0d",
                                              o_rsp.handled_count, want.handled_count));
                if (o_rsp.end_of_list !== want.end_of_list)
                    report_mismatch($sformatf("end_of_list got %0b want %0b on server %0d",
                                              o_rsp.end_of_list, want.end_of_list,
                                              want.server_index));
            end
        end
    end

    // Watchdog: end the run if no item moves on either channel for too long.
    always @(posedge i_clk) begin
        int unsigned quiet_cycles;
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item accepted for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side helpers.
    // ------------------------------------------------------------------
    function automatic rrfsd_pkg::t_req make_request(
        input logic [rrfsd_pkg::TIME_W-1:0] arrival,
        input logic [rrfsd_pkg::TIME_W-1:0] service,
        input logic                         final_flag
    );
        rrfsd_pkg::t_req r;
        r.arrival_time  = arrival;
        r.service_time  = service;
        r.final_request = final_flag;
        return r;
    endfunction

    // Offer one item and hold it until accepted; valid stays high afterwards
    // so a back-to-back item needs no second assignment in the same step.
    task automatic send_request(input rrfsd_pkg::t_req r);
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (!o_ready);
        requests_sent++;
        dispatch_request(r);
    endtask

    // Drop valid, wait for every owed item, then let the block go idle.
    task automatic settle();
        i_valid <= 1'b0;
        while (busiest_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_server_count(input logic [rrfsd_pkg::CFG_W-1:0] value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        server_setting = value;
        register_writes++;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [rrfsd_pkg::CFG_W-1:0] pick_server_count();
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd32;
            3:       return 6'd63;
            4:       return rrfsd_pkg::CFG_W'($urandom_range(33, 63));
            5, 6:    return rrfsd_pkg::CFG_W'($urandom_range(1, 4));
            default: return rrfsd_pkg::CFG_W'($urandom_range(1, 32));
        endcase
    endfunction

    // Send one batch; the last item is final. Dense mode packs arrivals close
    // together so servers collide and requests drop; wide mode spans all bits.
    task automatic run_batch(input int unsigned len, input bit dense, input bit split);
        logic [rrfsd_pkg::TIME_W-1:0] arrival;
        logic [rrfsd_pkg::TIME_W-1:0] service;
        arrival = dense ? rrfsd_pkg::TIME_W'($urandom_range(0, 32'h7FF0_0000)) : '0;
        for (int unsigned i = 0; i < len; i++) begin
            // Change k in the middle of an open batch: stale pointer cases.
            if (split && i == len / 2) write_server_count(pick_server_count());
            if (dense) begin
                arrival = arrival + rrfsd_pkg::TIME_W'($urandom_range(0, 6));
                service = rrfsd_pkg::TIME_W'($urandom_range(0, 40));
                if ($urandom_range(0, 15) == 0) service = rrfsd_pkg::TIME_W'($urandom());
            end else begin
                arrival = rrfsd_pkg::TIME_W'($urandom());
                service = rrfsd_pkg::TIME_W'($urandom());
            end
            send_request(make_request(arrival, service, i == len - 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset value of k is 32: a few servers used, the idle rest not listed.
    task automatic test_reset_default();
        send_request(make_request(31'd0, 31'd100, 1'b0));
        send_request(make_request(31'd0, 31'd100, 1'b0));
        send_request(make_request(31'd0, 31'd100, 1'b1));
    endtask

    // Largest arrival plus largest service fits in the 32-bit busy time without overflow.
    task automatic test_time_extremes();
        write_server_count(6'd1);
        send_request(make_request('1, '1, 1'b0));
        send_request(make_request('1, 31'd0, 1'b0));
        send_request(make_request(31'd0, 31'd0, 1'b1));
    endtask

    // A zero setting behaves as one server.
    task automatic test_zero_server_count();
        write_server_count(6'd0);
        send_request(make_request(31'd5, 31'd0, 1'b0));
        send_request(make_request(31'd5, 31'd0, 1'b0));
        send_request(make_request(31'd5, 31'd0, 1'b1));
    endtask

    // Settings above the server array are clamped to its size.
    task automatic test_oversized_server_count();
        write_server_count(6'd63);
        send_request(make_request(31'd0, 31'd50, 1'b0));
        send_request(make_request(31'd1, 31'd50, 1'b0));
        write_server_count(6'd33);
        send_request(make_request(31'd2, 31'd50, 1'b0));
        send_request(make_request(31'd3, 31'd50, 1'b1));
    endtask

    // Lower k past the start pointer mid-batch, then raise it again: the scan
    // restarts at server 0 and the servers above k keep their contents.
    task automatic test_stale_start_pointer();
        write_server_count(6'd8);
        repeat (6) send_request(make_request(31'd0, 31'd1000, 1'b0));
        write_server_count(6'd4);
        send_request(make_request(31'd10, 31'd5, 1'b0));
        write_server_count(6'd8);
        send_request(make_request(31'd10, 31'd5, 1'b1));
    endtask

    // All servers busy: the request is dropped and no count moves.
    task automatic test_dropped_requests();
        write_server_count(6'd2);
        send_request(make_request(31'd0, 31'd10, 1'b0));
        send_request(make_request(31'd0, 31'd10, 1'b0));
        send_request(make_request(31'd5, 31'd3, 1'b0));
        send_request(make_request(31'd10, 31'd0, 1'b0));
        send_request(make_request(31'd10, 31'd0, 1'b1));
    endtask

    task automatic test_random_batches();
        int unsigned goal;
        int unsigned len;
        goal = requests_sent + RANDOM_ITEMS;
        while (requests_sent < goal) begin
            write_server_count(pick_server_count());
            repeat ($urandom_range(1, 3)) begin
                len = (servers_in_use() <= 4) ? $urandom_range(1, 10)
                                              : $urandom_range(1, 40);
                run_batch(len, $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
            end
        end
    endtask

    // Hold the report side off while finals keep coming, so the output
    // register fills and o_ready stays low with a request waiting.
    task automatic test_output_backpressure();
        write_server_count(6'd32);
        hold_req = 1'b1;
        while (!holding) @(posedge i_clk);
        repeat (5) send_request(make_request(31'd0, 31'd1000, 1'b0));
        send_request(make_request(31'd0, 31'd1000, 1'b1));
        repeat (10) send_request(make_request(rrfsd_pkg::TIME_W'($urandom()),
                                              rrfsd_pkg::TIME_W'($urandom()), 1'b1));
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_stream();
        calm_phase = 1'b1;
        write_server_count(6'd32);
        run_batch(20, 1'b1, 1'b0);
        write_server_count(rrfsd_pkg::CFG_W'($urandom_range(1, 8)));
        run_batch(20, 1'b1, 1'b0);
    endtask

    initial begin
        server_setting = rrfsd_pkg::SERVER_COUNT_RST;
        clear_servers();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_default();
        test_time_extremes();
        test_zero_server_count();
        test_oversized_server_count();
        test_stale_start_pointer();
        test_dropped_requests();
        test_random_batches();
        test_output_backpressure();
        test_steady_stream();
        settle();

        $display("sent %0d requests, checked %0d busiest-server items, %0d register writes",
                 requests_sent, reports_seen, register_writes);
        $display({"k from 1 to 32 with zero and oversized settings, mid-batch k changes, ",
                  "dropped requests and a long report stall"});
        if (mismatches == 0 && busiest_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d items still owed", mismatches, busiest_queue.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
